>>> hdl/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared types and step codes for the reciprocal short-division unit.
// ----------------------------------------------------------------------------
package rsd_pkg;

    localparam int LIMB_W = 64;
    localparam int STEP_W = 4;

    // Sequencer steps; each one is a multiply followed by a write-back.
    localparam logic [STEP_W-1:0] STEP_V0_SQ    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_V1       = 4'd1;
    localparam logic [STEP_W-1:0] STEP_V1_D40   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_V2       = 4'd3;
    localparam logic [STEP_W-1:0] STEP_E        = 4'd4;
    localparam logic [STEP_W-1:0] STEP_V3       = 4'd5;
    localparam logic [STEP_W-1:0] STEP_V4       = 4'd6;
    localparam logic [STEP_W-1:0] STEP_DIV_EST  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_DIV_BACK = 4'd8;

    localparam logic [LIMB_W-1:0] NEWTON_ONE = 64'h1000_0000_0000_0000;

    typedef struct packed {
        logic                load_in;
        logic                seed;
        logic                mul_start;
        logic                post;
        logic [STEP_W-1:0]   step;
        logic                first_red;
        logic                corr1;
        logic                corr2;
        logic                out_load;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
    } stat_t;

endpackage

>>> hdl/reciprocal_short_division_by_limb_unit.sv
// ----------------------------------------------------------------------------
// reciprocal_short_division_by_limb_unit
// Divides a streamed multi-limb numerator by one normalized 64-bit divisor.
// ----------------------------------------------------------------------------
// Usage: write the divisor (top bit set) through cfg_wr_en/cfg_wr_data while
// the unit is idle. Numerator limbs then enter on the s_ channel, most
// significant first; s_tuser flags the first limb of a numerator and s_tlast
// the last one. Every input beat yields exactly one beat on the m_ channel
// carrying the quotient limb at that position and the running remainder,
// with m_tlast copied from the input.
// The unit takes one limb at a time and accepts the next limb only after
// the result of the previous one has been loaded into the output register.
// Each 64x64 multiply is built by the single 32x32 multiplier from four
// partial products in consecutive cycles. A first limb runs the reciprocal
// setup, seven multiplies. A later limb runs two multiplies and two
// correction steps.
// The result sits in an output register, so a stalled receiver does not stop
// the next limb from being accepted and worked on; only the write of its
// result waits until the previous beat has been taken.
// Reset (aresetn low, synchronous) sets the divisor to 2^63, clears the
// stored reciprocal and remainder, and drops m_tvalid.
// ----------------------------------------------------------------------------
module reciprocal_short_division_by_limb_unit (
    input  logic          aclk,
    input  logic          aresetn,
    // Configuration: divisor write.
    input  logic          cfg_wr_en,
    input  logic [63:0]   cfg_wr_data,
    // Input limbs.
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,   // [63:0] numerator_limb
    input  logic [0:0]    s_tuser,   // [0] first_limb
    input  logic          s_tlast,   // last_limb
    // Results.
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,   // [63:0] quotient_limb, [127:64] remainder
    output logic          m_tlast    // last
);

    rsd_pkg::cmd_t  cmd;
    rsd_pkg::stat_t stat;
    logic [63:0]    quo, rem;

    rsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_first  (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    rsd_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_limb       (s_tdata),
        .in_last       (s_tlast),
        .out_quotient  (quo),
        .out_remainder (rem),
        .out_last      (m_tlast)
    );

    assign m_tdata = {rem, quo};

endmodule

>>> hdl/rsd_mul.sv
// ----------------------------------------------------------------------------
// rsd_mul
// 64x64 to 128-bit multiplier built from one 32x32 multiplier, four partial
// products accumulated over successive cycles.
// ----------------------------------------------------------------------------
module rsd_mul (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [63:0]   a,
    input  logic [63:0]   b,
    output logic [127:0]  product,
    output logic          done
);

    logic [63:0]  a_reg, b_reg;
    logic [127:0] acc_reg;
    logic [63:0]  prod_reg;
    logic [1:0]   sh_reg;
    logic [2:0]   ph_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [31:0]  a_half, b_half;
    logic [127:0] addend;

    // Partial product ph uses a half (ph[1]) and b half (ph[0]).
    assign a_half = ph_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half = ph_reg[0] ? b_reg[63:32] : b_reg[31:0];
    assign addend = {64'd0, prod_reg} << {sh_reg, 5'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ph_reg   <= 3'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                ph_reg   <= 3'd0;
            end else if (busy_reg) begin
                ph_reg <= ph_reg + 3'd1;
                if (ph_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (ph_reg != 3'd4) begin
                prod_reg <= a_half * b_half;
                sh_reg   <= {1'b0, ph_reg[1]} + {1'b0, ph_reg[0]};
            end
            if (ph_reg != 3'd0) begin
                acc_reg <= acc_reg + addend;
            end
        end
    end

    assign product = acc_reg;
    assign done    = done_reg;

endmodule

>>> hdl/rsd_datapath.sv
// ----------------------------------------------------------------------------
// rsd_datapath
// Registers and arithmetic for reciprocal setup and 2-by-1 limb division.
// ----------------------------------------------------------------------------
module rsd_datapath (
    input  logic          aclk,
    input  logic          aresetn,
    input  rsd_pkg::cmd_t cmd,
    output rsd_pkg::stat_t stat,
    input  logic          cfg_wr_en,
    input  logic [63:0]   cfg_wr_data,
    input  logic [63:0]   in_limb,
    input  logic          in_last,
    output logic [63:0]   out_quotient,
    output logic [63:0]   out_remainder,
    output logic          out_last
);

    logic [63:0]  d_reg, recip_reg, prem_reg, limb_reg;
    logic         last_reg;
    logic [63:0]  v_reg, w_reg, d63_reg, q_reg, r_reg, q0_reg;
    logic [40:0]  d40_reg;
    logic [63:0]  oq_reg, or_reg;
    logic         ol_reg;
    logic [10:0]  seed_tab [256];
    logic [63:0]  mul_a, mul_b;
    logic [127:0] prod;
    logic [63:0]  lo, hi, lo2, hi2, q0n;
    logic         c6, c7;

    // Seed table: floor(0x7fd00 / (256 + i)).
    for (genvar i = 0; i < 256; i++) begin : g_seed
        localparam logic [10:0] SEED_VAL = 11'(20'h7FD00 / (256 + i));
        assign seed_tab[i] = SEED_VAL;
    end

    always_comb begin
        mul_a = v_reg;
        mul_b = w_reg;
        case (cmd.step)
            rsd_pkg::STEP_V0_SQ:    begin mul_a = v_reg;    mul_b = v_reg;     end
            rsd_pkg::STEP_V1:       begin mul_a = w_reg;    mul_b = {23'd0, d40_reg}; end
            rsd_pkg::STEP_V1_D40:   begin mul_a = v_reg;    mul_b = {23'd0, d40_reg}; end
            rsd_pkg::STEP_V2:       begin mul_a = v_reg;    mul_b = w_reg;     end
            rsd_pkg::STEP_E:        begin mul_a = v_reg;    mul_b = d63_reg;   end
            rsd_pkg::STEP_V3:       begin mul_a = v_reg;    mul_b = w_reg;     end
            rsd_pkg::STEP_V4:       begin mul_a = v_reg;    mul_b = d_reg;     end
            rsd_pkg::STEP_DIV_EST:  begin mul_a = prem_reg; mul_b = recip_reg; end
            rsd_pkg::STEP_DIV_BACK: begin mul_a = q_reg;    mul_b = d_reg;     end
            default:                begin mul_a = v_reg;    mul_b = w_reg;     end
        endcase
    end

    rsd_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .product (prod),
        .done    (stat.mul_done)
    );

    assign lo  = prod[63:0];
    assign hi  = prod[127:64];
    assign lo2 = lo + d_reg;
    assign c6  = lo2 < d_reg;
    assign hi2 = hi + d_reg + {63'd0, c6};
    assign q0n = lo + limb_reg;
    assign c7  = q0n < limb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg     <= 64'h8000_0000_0000_0000;
            recip_reg <= '0;
            prem_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                d_reg <= cfg_wr_data;
            end
            if (cmd.post && cmd.step == rsd_pkg::STEP_V4) begin
                recip_reg <= v_reg - hi2;
            end
            if (cmd.out_load) begin
                prem_reg <= r_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            limb_reg <= in_limb;
            last_reg <= in_last;
        end
        if (cmd.seed) begin
            v_reg   <= {53'd0, seed_tab[d_reg[62:55]]};
            d40_reg <= {1'b0, d_reg[63:24]} + 41'd1;
            d63_reg <= {1'b0, d_reg[63:1]} + {63'd0, d_reg[0]};
        end
        if (cmd.post) begin
            case (cmd.step)
                rsd_pkg::STEP_V0_SQ:   w_reg <= lo;
                rsd_pkg::STEP_V1:      v_reg <= (v_reg << 11) - (lo >> 40) - 64'd1;
                rsd_pkg::STEP_V1_D40:  w_reg <= rsd_pkg::NEWTON_ONE - lo;
                rsd_pkg::STEP_V2:      v_reg <= (v_reg << 13) + (lo >> 47);
                rsd_pkg::STEP_E:       w_reg <= ((v_reg >> 1) & {64{d_reg[0]}}) - lo;
                rsd_pkg::STEP_V3:      v_reg <= (v_reg << 31) + (hi >> 1);
                rsd_pkg::STEP_DIV_EST: begin
                    q0_reg <= q0n;
                    q_reg  <= hi + prem_reg + {63'd0, c7} + 64'd1;
                end
                rsd_pkg::STEP_DIV_BACK: r_reg <= limb_reg - lo;
                default: ;
            endcase
        end
        if (cmd.first_red) begin
            if (limb_reg >= d_reg) begin
                q_reg <= 64'd1;
                r_reg <= limb_reg - d_reg;
            end else begin
                q_reg <= 64'd0;
                r_reg <= limb_reg;
            end
        end
        if (cmd.corr1 && r_reg >= q0_reg) begin
            q_reg <= q_reg - 64'd1;
            r_reg <= r_reg + d_reg;
        end
        if (cmd.corr2 && r_reg >= d_reg) begin
            q_reg <= q_reg + 64'd1;
            r_reg <= r_reg - d_reg;
        end
        if (cmd.out_load) begin
            oq_reg <= q_reg;
            or_reg <= r_reg;
            ol_reg <= last_reg;
        end
    end

    assign out_quotient  = oq_reg;
    assign out_remainder = or_reg;
    assign out_last      = ol_reg;

endmodule

>>> hdl/rsd_ctrl.sv
// ----------------------------------------------------------------------------
// rsd_ctrl
// Sequencer for the division unit: steps the datapath through reciprocal
// setup and limb division, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module rsd_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic           s_first,
    output logic           m_tvalid,
    input  logic           m_tready,
    output rsd_pkg::cmd_t  cmd,
    input  rsd_pkg::stat_t stat
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SEED   = 4'd1;
    localparam logic [3:0] ST_MSTART = 4'd2;
    localparam logic [3:0] ST_MWAIT  = 4'd3;
    localparam logic [3:0] ST_POST   = 4'd4;
    localparam logic [3:0] ST_FRED   = 4'd5;
    localparam logic [3:0] ST_CORR1  = 4'd6;
    localparam logic [3:0] ST_CORR2  = 4'd7;
    localparam logic [3:0] ST_OUT    = 4'd8;

    logic [3:0]                  state_reg, state_next;
    logic [rsd_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        mv_reg, mv_next;
    logic                        out_free;

    assign out_free = !mv_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    if (s_first) begin
                        state_next = ST_SEED;
                    end else begin
                        step_next  = rsd_pkg::STEP_DIV_EST;
                        state_next = ST_MSTART;
                    end
                end
            end
            ST_SEED: begin
                cmd.seed   = 1'b1;
                step_next  = rsd_pkg::STEP_V0_SQ;
                state_next = ST_MSTART;
            end
            ST_MSTART: begin
                cmd.mul_start = 1'b1;
                state_next    = ST_MWAIT;
            end
            ST_MWAIT: begin
                if (stat.mul_done) begin
                    state_next = ST_POST;
                end
            end
            ST_POST: begin
                cmd.post = 1'b1;
                if (step_reg == rsd_pkg::STEP_V4) begin
                    state_next = ST_FRED;
                end else if (step_reg == rsd_pkg::STEP_DIV_BACK) begin
                    state_next = ST_CORR1;
                end else begin
                    step_next  = step_reg + 4'd1;
                    state_next = ST_MSTART;
                end
            end
            ST_FRED: begin
                cmd.first_red = 1'b1;
                state_next    = ST_OUT;
            end
            ST_CORR1: begin
                cmd.corr1  = 1'b1;
                state_next = ST_CORR2;
            end
            ST_CORR2: begin
                cmd.corr2  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            mv_next = 1'b1;
        end else if (m_tready) begin
            mv_next = 1'b0;
        end else begin
            mv_next = mv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= rsd_pkg::STEP_V0_SQ;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            mv_reg    <= mv_next;
        end
    end

endmodule

>>> hdl/rsd_checker.sv
// ----------------------------------------------------------------------------
// rsd_checker
// Port-level checks on the division unit over time.
// ----------------------------------------------------------------------------
module rsd_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);

    // A waiting result holds still until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // One limb at a time: after a beat is taken the input closes.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted again while a limb is in work");

    // A limb runs at least one multiply before its result is loaded, so no result appears right after a beat.
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result produced right after a limb was taken");

    // Out of reset the unit is empty and ready.
    a_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid && s_tready)
        else $error("unit not empty after reset");

endmodule

bind reciprocal_short_division_by_limb_unit rsd_checker u_rsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> sim/reciprocal_short_division_by_limb_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reciprocal_short_division_by_limb_unit_test
// Self-checking bench for the streamed limb divider. Numerators are sent as
// limb beats, most significant first, under several divisors. A scoreboard
// recomputes the reciprocal and every 2-by-1 division step to predict each
// quotient limb and remainder, and checks every result beat in order.
// ----------------------------------------------------------------------------
module reciprocal_short_division_by_limb_unit_test;

    typedef struct {
        bit [rsd_pkg::LIMB_W-1:0] quotient;
        bit [rsd_pkg::LIMB_W-1:0] remainder;
        bit                       last;
    } division_step_t;

    // Holds the divider's state and the queue of predicted result beats.
    class limb_division_scoreboard;
        bit [rsd_pkg::LIMB_W-1:0] divisor;
        bit [rsd_pkg::LIMB_W-1:0] running_rem;
        bit [rsd_pkg::LIMB_W-1:0] recip;
        division_step_t           pending_steps[$];
        int                       mismatches;

        function new();
            divisor     = 64'h8000_0000_0000_0000;
            running_rem = '0;
            recip       = '0;
            mismatches  = 0;
        endfunction

        // floor((2^128-1)/d) - 2^64 by table seed and Newton refinement.
        function bit [rsd_pkg::LIMB_W-1:0] derive_reciprocal(bit [rsd_pkg::LIMB_W-1:0] d);
            bit [rsd_pkg::LIMB_W-1:0]   d40, v0, v1, v2, v3, d63, e, t, mask, idx;
            bit [2*rsd_pkg::LIMB_W-1:0] p;
            idx  = ((d >> 55) - 64'd256) & 64'hFF;
            v0   = 64'h7FD00 / (64'd256 + idx);
            d40  = (d >> 24) + 64'd1;
            t    = v0 * v0;
            t    = t * d40;
            v1   = (v0 << 11) - (t >> 40) - 64'd1;
            t    = v1 * d40;
            t    = rsd_pkg::NEWTON_ONE - t;
            t    = v1 * t;
            v2   = (v1 << 13) + (t >> 47);
            d63  = (d >> 1) + {63'd0, d[0]};
            mask = d[0] ? '1 : '0;
            t    = v2 * d63;
            e    = ((v2 >> 1) & mask) - t;
            p    = {64'd0, v2} * {64'd0, e};
            v3   = (v2 << 31) + (p[127:64] >> 1);
            // High half of (v3 + 2^64 + 1) * d.
            p    = {64'd0, v3} * {64'd0, d} + {64'd0, d} + {d, 64'd0};
            return v3 - p[127:64];
        endfunction

        function void note_limb(bit [rsd_pkg::LIMB_W-1:0] limb, bit first, bit last);
            division_step_t             s;
            bit [2*rsd_pkg::LIMB_W-1:0] p;
            bit [rsd_pkg::LIMB_W-1:0]   q, r;
            if (first) begin
                recip = derive_reciprocal(divisor);
                if (limb >= divisor) begin
                    q = 64'd1;
                    r = limb - divisor;
                end else begin
                    q = 64'd0;
                    r = limb;
                end
            end else begin
                // Quotient estimate from running_rem:limb, then two corrections.
                p = {64'd0, running_rem} * {64'd0, recip} + {64'd0, limb}
                    + {running_rem, 64'd0};
                q = p[127:64] + 64'd1;
                t_mul(q, r, limb);
                if (r >= p[63:0]) begin
                    q = q - 64'd1;
                    r = r + divisor;
                end
                if (r >= divisor) begin
                    q = q + 64'd1;
                    r = r - divisor;
                end
            end
            running_rem = r;
            s.quotient  = q;
            s.remainder = r;
            s.last      = last;
            pending_steps.push_back(s);
        endfunction

        function void t_mul(bit [rsd_pkg::LIMB_W-1:0] q,
                            output bit [rsd_pkg::LIMB_W-1:0] r,
                            input bit [rsd_pkg::LIMB_W-1:0] limb);
            r = limb - q * divisor;
        endfunction

        function void check_result(bit [rsd_pkg::LIMB_W-1:0] q,
                                   bit [rsd_pkg::LIMB_W-1:0] r, bit last);
            division_step_t s;
            if (pending_steps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat: q=%h r=%h last=%0b", q, r, last);
                return;
            end
            s = pending_steps.pop_front();
            if (s.quotient !== q || s.remainder !== r || s.last !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected q=%h r=%h last=%0b, got q=%h r=%h last=%0b",
                             s.quotient, s.remainder, s.last, q, r, last);
            end
        endfunction
    endclass

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          cfg_wr_en = 1'b0;
    logic [63:0]   cfg_wr_data = '0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [63:0]   s_tdata = '0;     // [63:0] numerator_limb
    logic [0:0]    s_tuser = '0;     // [0] first_limb
    logic          s_tlast = 1'b0;   // last_limb
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [127:0]  m_tdata;          // [63:0] quotient_limb, [127:64] remainder
    logic          m_tlast;          // last

    limb_division_scoreboard sb = new();
    int  burst_left = 0;
    int  idle_cycles = 0;
    bit  reset_done = 1'b0;

    always #10 aclk = ~aclk;

    reciprocal_short_division_by_limb_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    // Both channels are observed at the rising edge. An accepted input beat
    // is noted before any result is checked; results come from limbs accepted
    // earlier, so the order within one edge never matters.
    always @(posedge aclk) begin
        if (reset_done) begin
            if (s_tvalid && s_tready)
                sb.note_limb(s_tdata, s_tuser[0], s_tlast);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[63:0], m_tdata[127:64], m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= 5000) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Receiver: rotates between always ready, random stalls and a fixed
    // pattern. Once, it holds off for a long stretch so that the output
    // register fills, the next limb completes and the input stalls.
    initial begin : receiver
        int rx_cycle;
        int mode;
        rx_cycle = 0;
        forever begin
            @(negedge aclk);
            rx_cycle++;
            if (rx_cycle == 3000) begin
                m_tready <= 1'b0;
                repeat (600) @(negedge aclk);
            end
            mode = (rx_cycle / 256) % 3;
            case (mode)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    m_tready <= (rx_cycle % 5) != 0;
                end
            endcase
        end
    end

    // Called at a falling edge, returns at a falling edge after the beat
    // was taken. Beats go out in bursts, most of them separated by random gaps.
    task automatic send_limb(input bit [63:0] limb, input bit first, input bit last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= limb;
        s_tuser[0] <= first;
        s_tlast    <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        burst_left--;
    endtask

    // The divisor is only written with nothing in flight. After the last
    // result a short pause covers any limb still being worked on.
    task automatic write_divisor(input bit [63:0] value);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending_steps.size() != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        sb.divisor = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic bit [63:0] pick_limb(bit [63:0] d);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return d;
            3: return d - 64'd1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin : stimulus
        bit [63:0] divisors[7];
        bit [63:0] d;
        int        len;
        int        sent;
        divisors = '{64'h8000_0000_0000_0000, '1, 64'h8000_0000_0000_0001,
                     64'hC000_0000_0000_0000, 64'h0, 64'h0, 64'h0};
        for (int i = 4; i < 7; i++)
            divisors[i] = {1'b1, 31'($urandom), 32'($urandom)};

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn    <= 1'b1;
        reset_done = 1'b1;

        // A later limb straight after reset runs on the cleared state.
        send_limb(64'h0123_4567_89AB_CDEF, 1'b0, 1'b0);
        // Three-limb numerator under the reset divisor.
        send_limb('0, 1'b1, 1'b0);
        send_limb('1, 1'b0, 1'b0);
        send_limb(64'd1, 1'b0, 1'b1);
        // One-limb numerators around the divisor.
        send_limb('1, 1'b1, 1'b1);
        send_limb(64'h8000_0000_0000_0000, 1'b1, 1'b1);
        send_limb(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
        // Continuing after a last limb from the kept remainder.
        send_limb(64'hFFFF_0000_FFFF_0000, 1'b0, 1'b1);
        write_divisor('1);
        send_limb('1, 1'b1, 1'b0);
        send_limb('1, 1'b0, 1'b0);
        send_limb('0, 1'b0, 1'b1);
        send_limb(64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b1);
        // Divisor changed in the middle of a numerator.
        send_limb(64'h5555_5555_5555_5555, 1'b1, 1'b0);
        write_divisor(64'h9E37_79B9_7F4A_7C15);
        send_limb(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0);
        send_limb('1, 1'b0, 1'b1);

        // Random phases, one divisor each. Most numerators are well formed;
        // about one in ten has random first and last flags.
        for (int ph = 0; ph < 7; ph++) begin
            d = divisors[ph];
            write_divisor(d);
            sent = 0;
            while (sent < 150) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16)
                                                  : $urandom_range(1, 6);
                if ($urandom_range(0, 9) == 0) begin
                    for (int k = 0; k < len; k++)
                        send_limb(pick_limb(d), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)));
                end else begin
                    for (int k = 0; k < len; k++)
                        send_limb(pick_limb(d), k == 0, k == len - 1);
                end
                sent += len;
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending_steps.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_steps.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
